// ----- sv/pcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants for the polygon centroid fan core
// Widths of the ports and accumulators, default parameter values and the
// per-polygon job that passes from the accumulator to the divider side.
// ----------------------------------------------------------------------------
package pcf_pkg;

	localparam int COORD_W          = 16;
	localparam int AREA_W           = 40;
	localparam int MOM_W            = 64;
	localparam int DEN_W            = AREA_W + 2;
	localparam int QDEPTH           = 2;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;

	typedef struct packed {
		logic [MOM_W-1:0]  mom_x;
		logic [MOM_W-1:0]  mom_y;
		logic [AREA_W-1:0] area;
		logic              degen;
	} job_t;

endpackage

// ----- sv/pcf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front: vertex accumulator
// Keeps origin and previous vertex, forms twice the signed triangle area and
// the area-weighted corner sums, and hands one job per polygon to the queue.
// ----------------------------------------------------------------------------
module pcf_front #(
	parameter int MAX_VERTICES = pcf_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pcf_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pcf_pkg::COORD_W-1:0]  vertex_x,
	input  logic [pcf_pkg::COORD_W-1:0]  vertex_y,
	input  logic                         last_vertex,
	input  logic                         push,
	output logic                         full,
	output logic                         job_push,
	output pcf_pkg::job_t                job,
	input  logic                         job_full
);

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int PW    = 2 * DW;
	localparam int AW2   = PW + 1;
	localparam int SW    = CB + 2;
	localparam int MW    = AW2 + SW + 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AREA_W = pcf_pkg::AREA_W;
	localparam int MOM_W  = pcf_pkg::MOM_W;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_MOM, F_ACC} state_t;

	state_t               state_q;
	logic [CB-1:0]        org_x_q, org_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AREA_W-1:0]    area_q;
	logic [MOM_W-1:0]     mom_x_q, mom_y_q;

	logic signed [DW-1:0] cx_s1, cy_s1, px_s1, py_s1;
	logic [SW-1:0]        sx_s1, sy_s1;
	logic                 acc_s1, last_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [MW-1:0] mx_s3, my_s3;

	logic [CB-1:0]        xin, yin;
	logic signed [DW-1:0] cx, cy, px, py;
	logic [SW-1:0]        sx, sy;
	logic signed [AW2-1:0] a2;
	logic [MOM_W-1:0]     mom_x_nx, mom_y_nx;
	logic                 accept, advance;

	assign xin    = vertex_x[CB-1:0];
	assign yin    = vertex_y[CB-1:0];
	assign cx     = $signed({1'b0, xin}) - $signed({1'b0, org_x_q});
	assign cy     = $signed({1'b0, yin}) - $signed({1'b0, org_y_q});
	assign px     = $signed({1'b0, prev_x_q}) - $signed({1'b0, org_x_q});
	assign py     = $signed({1'b0, prev_y_q}) - $signed({1'b0, org_y_q});
	assign sx     = SW'(org_x_q) + SW'(prev_x_q) + SW'(xin);
	assign sy     = SW'(org_y_q) + SW'(prev_y_q) + SW'(yin);
	assign a2     = $signed({p1_s2[PW-1], p1_s2}) - $signed({p2_s2[PW-1], p2_s2});

	assign mom_x_nx = acc_s1 ? mom_x_q + {{(MOM_W-MW){mx_s3[MW-1]}}, mx_s3} : mom_x_q;
	assign mom_y_nx = acc_s1 ? mom_y_q + {{(MOM_W-MW){my_s3[MW-1]}}, my_s3} : mom_y_q;

	assign full     = (state_q != F_IDLE);
	assign accept   = push && !full;
	assign advance  = !last_s1 || !job_full;
	assign job_push = (state_q == F_ACC) && last_s1 && !job_full;

	always_comb begin
		job.mom_x = mom_x_nx;
		job.mom_y = mom_y_nx;
		job.area  = area_q;
		job.degen = (cnt_q < CNT_W'(3)) || (area_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			org_x_q  <= '0;
			org_y_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			cnt_q    <= '0;
			area_q   <= '0;
			mom_x_q  <= '0;
			mom_y_q  <= '0;
			acc_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						cx_s1   <= cx;
						cy_s1   <= cy;
						px_s1   <= px;
						py_s1   <= py;
						sx_s1   <= sx;
						sy_s1   <= sy;
						last_s1 <= last_vertex;
						acc_s1  <= (cnt_q < CNT_W'(MAX_VERTICES)) && (cnt_q >= CNT_W'(2));
						if (cnt_q < CNT_W'(MAX_VERTICES)) begin
							if (cnt_q == '0) begin
								org_x_q <= xin;
								org_y_q <= yin;
							end
							prev_x_q <= xin;
							prev_y_q <= yin;
							cnt_q    <= cnt_q + CNT_W'(1);
						end
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					p1_s2   <= cx_s1 * py_s1;
					p2_s2   <= cy_s1 * px_s1;
					state_q <= F_MOM;
				end
				F_MOM: begin
					mx_s3 <= a2 * $signed({1'b0, sx_s1});
					my_s3 <= a2 * $signed({1'b0, sy_s1});
					if (acc_s1) begin
						area_q <= area_q + {{(AREA_W-AW2){a2[AW2-1]}}, a2};
					end
					state_q <= F_ACC;
				end
				F_ACC: begin
					if (advance) begin
						if (last_s1) begin
							cnt_q   <= '0;
							area_q  <= '0;
							mom_x_q <= '0;
							mom_y_q <= '0;
						end else begin
							mom_x_q <= mom_x_nx;
							mom_y_q <= mom_y_nx;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/pcf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_fifo: short job queue
// Decouples the accumulator from the divider side; holds whole polygon jobs.
// ----------------------------------------------------------------------------
module pcf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcf_pkg::job_t  din,
	output logic           full,
	input  logic           pop,
	output pcf_pkg::job_t  dout,
	output logic           empty
);

	localparam int DEPTH = pcf_pkg::QDEPTH;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	pcf_pkg::job_t  mem_q [DEPTH];
	logic [IW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + IW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + IW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/pcf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses for a single cycle as the final
// quotient and remainder are registered.
module pcf_div #(
	parameter int NUM_W = pcf_pkg::MOM_W,
	parameter int DEN_W = pcf_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quot  = quo_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= CW'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/pcf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_back: centroid division and result register
// Takes one job at a time, divides both moments by three times the area on a
// shared divider, rounds and clips, and holds the result until popped.
// ----------------------------------------------------------------------------
module pcf_back #(
	parameter int COORD_BITS = pcf_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pcf_pkg::job_t                job,
	input  logic                         job_empty,
	output logic                         job_pop,
	output logic [pcf_pkg::COORD_W-1:0]  centroid_x,
	output logic [pcf_pkg::COORD_W-1:0]  centroid_y,
	output logic                         degenerate,
	output logic                         saturated,
	output logic                         empty,
	input  logic                         pop
);

	localparam int MOM_W   = pcf_pkg::MOM_W;
	localparam int AREA_W  = pcf_pkg::AREA_W;
	localparam int DEN_W   = pcf_pkg::DEN_W;
	localparam int COORD_W = pcf_pkg::COORD_W;
	localparam int QW      = MOM_W + 1;

	typedef enum logic [1:0] {B_IDLE, B_DIVX, B_DIVY, B_HOLD} state_t;

	state_t               state_q;
	logic [DEN_W-1:0]     den_q;
	logic [MOM_W-1:0]     num_y_q;
	logic                 neg_x_q, neg_y_q, den_neg_q;
	logic [COORD_W-1:0]   px_q, py_q;
	logic                 pdeg_q, psat_q;
	logic [COORD_W-1:0]   out_x_q, out_y_q;
	logic                 out_deg_q, out_sat_q, out_valid_q;

	logic                 hd_neg;
	logic [AREA_W-1:0]    a_mag;
	logic [DEN_W-1:0]     den_mag;
	logic [MOM_W-1:0]     num_x_mag, num_y_mag;
	logic                 div_start, div_done;
	logic [MOM_W-1:0]     div_num, div_quot;
	logic [DEN_W-1:0]     div_den, div_rem;
	logic                 rnd, cur_neg, csat, out_free, out_load;
	logic [QW-1:0]        q_r, lim;
	logic [COORD_W-1:0]   coord;

	assign hd_neg    = job.area[AREA_W-1];
	assign a_mag     = hd_neg ? (~job.area + AREA_W'(1)) : job.area;
	assign den_mag   = {2'b00, a_mag} + {1'b0, a_mag, 1'b0};
	assign num_x_mag = job.mom_x[MOM_W-1] ? (~job.mom_x + MOM_W'(1)) : job.mom_x;
	assign num_y_mag = job.mom_y[MOM_W-1] ? (~job.mom_y + MOM_W'(1)) : job.mom_y;

	assign job_pop   = (state_q == B_IDLE) && !job_empty;
	assign div_start = (job_pop && !job.degen) || ((state_q == B_DIVX) && div_done);
	assign div_num   = (state_q == B_IDLE) ? num_x_mag : num_y_q;
	assign div_den   = (state_q == B_IDLE) ? den_mag : den_q;

	pcf_div #(
		.NUM_W (MOM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// round half away from zero, then clip to the coordinate range
	assign lim     = {{(QW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
	assign rnd     = ({div_rem, 1'b0} >= {1'b0, den_q});
	assign q_r     = {1'b0, div_quot} + QW'(rnd);
	assign cur_neg = (state_q == B_DIVX) ? neg_x_q : neg_y_q;

	always_comb begin
		coord = '0;
		csat  = 1'b0;
		if (q_r == '0) begin
			coord = '0;
		end else if (cur_neg != den_neg_q) begin
			csat = 1'b1;
		end else if (q_r > lim) begin
			coord = lim[COORD_W-1:0];
			csat  = 1'b1;
		end else begin
			coord = q_r[COORD_W-1:0];
		end
	end

	assign out_free   = !out_valid_q || pop;
	assign out_load   = (state_q == B_HOLD) && out_free;
	assign empty      = !out_valid_q;
	assign centroid_x = out_x_q;
	assign centroid_y = out_y_q;
	assign degenerate = out_deg_q;
	assign saturated  = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			den_q       <= '0;
			num_y_q     <= '0;
			neg_x_q     <= 1'b0;
			neg_y_q     <= 1'b0;
			den_neg_q   <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pdeg_q      <= 1'b0;
			psat_q      <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_deg_q   <= 1'b0;
			out_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !pop);
			unique case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						den_q     <= den_mag;
						num_y_q   <= num_y_mag;
						neg_x_q   <= job.mom_x[MOM_W-1];
						neg_y_q   <= job.mom_y[MOM_W-1];
						den_neg_q <= hd_neg;
						px_q      <= '0;
						py_q      <= '0;
						psat_q    <= 1'b0;
						pdeg_q    <= job.degen;
						state_q   <= job.degen ? B_HOLD : B_DIVX;
					end
				end
				B_DIVX: begin
					if (div_done) begin
						px_q    <= coord;
						psat_q  <= csat;
						state_q <= B_DIVY;
					end
				end
				B_DIVY: begin
					if (div_done) begin
						py_q    <= coord;
						psat_q  <= psat_q || csat;
						state_q <= B_HOLD;
					end
				end
				B_HOLD: begin
					if (out_load) begin
						out_x_q   <= px_q;
						out_y_q   <= py_q;
						out_deg_q <= pdeg_q;
						out_sat_q <= psat_q;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/polygon_centroid_fan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_centroid_fan_core: polygon centroid by triangle fan
// Accumulates signed fan areas and moments per vertex; divides per polygon.
// ----------------------------------------------------------------------------
//  channel  | handshake        | fields
//  vertex   | push / full      | vertex_x, vertex_y, last_vertex
//  centroid | empty / pop      | centroid_x, centroid_y, degenerate, saturated
//
//  A vertex passes the accumulator states F_MUL and F_MOM (two multiplier
//  stages, with the area add in F_MOM) and F_ACC (moment add); full is high
//  from each accept until F_ACC returns to idle. The x and y divisions of a
//  polygon share the one-bit-per-cycle divider; degenerate polygons skip it.
//  Up to two polygon jobs queue between the sides; the accumulator stalls on
//  a closing vertex only while that queue is full.
//  Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_centroid_fan_core #(
	parameter int MAX_VERTICES = pcf_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pcf_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pcf_pkg::COORD_W-1:0]  vertex_x,
	input  logic [pcf_pkg::COORD_W-1:0]  vertex_y,
	input  logic                         last_vertex,
	input  logic                         push,
	output logic                         full,
	output logic [pcf_pkg::COORD_W-1:0]  centroid_x,
	output logic [pcf_pkg::COORD_W-1:0]  centroid_y,
	output logic                         degenerate,
	output logic                         saturated,
	output logic                         empty,
	input  logic                         pop
);

	pcf_pkg::job_t job_in, job_out;
	logic          q_push, q_full, q_pop, q_empty;

	pcf_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.push        (push),
		.full        (full),
		.job_push    (q_push),
		.job         (job_in),
		.job_full    (q_full)
	);

	pcf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (job_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (job_out),
		.empty  (q_empty)
	);

	pcf_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_out),
		.job_empty  (q_empty),
		.job_pop    (q_pop),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.degenerate (degenerate),
		.saturated  (saturated),
		.empty      (empty),
		.pop        (pop)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("accumulator took a vertex without going busy");

	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_queue_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && degenerate |-> centroid_x == '0 && centroid_y == '0 && !saturated)
		else $error("degenerate item carries a nonzero centroid");

endmodule

// ----- tb/tb_polygon_centroid_fan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_centroid_fan_core: self-checking bench for the fan centroid core
// Drives polygons one vertex per item: a short directed script (degenerate,
// collinear, zero-area bowtie, square, extreme triangle, clipping both ways),
// then random scattered, clustered, rectangular and overlong polygons.
// A local fan accumulator and rounding divider predict untyped centroids; both
// handshakes idle at random and the output is held off once to back up input.
// ----------------------------------------------------------------------------
module tb_polygon_centroid_fan_core;

	localparam int COORD_W       = pcf_pkg::COORD_W;
	localparam int AREA_W        = pcf_pkg::AREA_W;
	localparam int MOM_W         = pcf_pkg::MOM_W;
	localparam int MAX_VERTS     = pcf_pkg::MAX_VERTICES_DEF;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 500;
	localparam int HOLD_AT       = 15;
	localparam int HOLD_CYCLES   = 2000;
	localparam int DRAIN_CYCLES  = 400;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic               degen;
		logic               sat;
	} centroid_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               is_last;
		logic               typed;
		centroid_t          want;
	} vertex_row_t;

	typedef enum int {SHAPE_SCATTER, SHAPE_CLUSTER, SHAPE_RECT} shape_t;

	localparam centroid_t NO_RESULT    = '0;
	localparam centroid_t DEGEN_RESULT = '{16'd0, 16'd0, 1'b1, 1'b0};
	localparam centroid_t SQUARE_MID   = '{16'd8, 16'd8, 1'b0, 1'b0};
	localparam centroid_t BOWTIE_LOW   = '{16'd0, 16'd3, 1'b0, 1'b1};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic [COORD_W-1:0] vertex_x    = '0;
	logic [COORD_W-1:0] vertex_y    = '0;
	logic               last_vertex = 1'b0;
	logic               push        = 1'b0;
	logic               pop         = 1'b0;
	logic               full;
	logic [COORD_W-1:0] centroid_x;
	logic [COORD_W-1:0] centroid_y;
	logic               degenerate;
	logic               saturated;
	logic               empty;

	centroid_t expected_centroids[$];
	int        mismatches = 0;
	int        sent_items = 0;
	int        send_calm  = 0;
	int        recv_calm  = 0;

	// fan accumulator mirror
	bit [COORD_W-1:0] fan_origin_x, fan_origin_y, fan_prev_x, fan_prev_y;
	int               fan_count = 0;
	bit [AREA_W-1:0]  fan_area  = '0;
	bit [MOM_W-1:0]   fan_mom_x = '0;
	bit [MOM_W-1:0]   fan_mom_y = '0;

	vertex_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'd0,     16'd0,     1'b1, 1'b1, DEGEN_RESULT},
		'{16'd65535, 16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{16'd0,     16'd0,     1'b1, 1'b1, DEGEN_RESULT},
		'{16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd100,   16'd100,   1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 16'd65535, 1'b1, 1'b1, DEGEN_RESULT},
		'{16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd4,     16'd4,     1'b0, 1'b0, NO_RESULT},
		'{16'd4,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd0,     16'd4,     1'b1, 1'b1, DEGEN_RESULT},
		'{16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd16,    16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd16,    16'd16,    1'b0, 1'b0, NO_RESULT},
		'{16'd0,     16'd16,    1'b1, 1'b1, SQUARE_MID},
		'{16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 16'd65535, 1'b1, 1'b0, NO_RESULT},
		'{16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd4,     16'd4,     1'b0, 1'b0, NO_RESULT},
		'{16'd4,     16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd0,     16'd5,     1'b1, 1'b1, BOWTIE_LOW},
		'{16'd65535, 16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{16'd65531, 16'd65531, 1'b0, 1'b0, NO_RESULT},
		'{16'd65531, 16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 16'd65530, 1'b1, 1'b0, NO_RESULT}
	};

	polygon_centroid_fan_core #(
		.MAX_VERTICES(MAX_VERTS),
		.COORD_BITS  (pcf_pkg::COORD_BITS_DEF)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.last_vertex(last_vertex),
		.push       (push),
		.full       (full),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.degenerate (degenerate),
		.saturated  (saturated),
		.empty      (empty),
		.pop        (pop)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// nearest rounding, ties away from zero, clipped to the coordinate range
	function automatic bit [COORD_W-1:0] round_centroid(input bit [MOM_W-1:0] num,
			input bit den_neg, input bit [MOM_W-1:0] den_mag, inout bit sat);
		bit [MOM_W-1:0] mag, q, r;
		mag = num[MOM_W-1] ? -num : num;
		q = mag / den_mag;
		r = mag % den_mag;
		if (r >= den_mag - r)
			q++;
		if (q == 0)
			return '0;
		if (num[MOM_W-1] != den_neg) begin
			sat = 1'b1;
			return '0;
		end
		if ((q >> COORD_W) != 0) begin
			sat = 1'b1;
			return '1;
		end
		return q[COORD_W-1:0];
	endfunction

	function automatic bit fan_step(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
			input bit is_last, output centroid_t res);
		longint          px, py, qx, qy, a2, sx, sy;
		bit              den_neg, sat;
		bit [AREA_W-1:0] a_mag;
		bit [MOM_W-1:0]  den_mag;
		res = NO_RESULT;
		if (fan_count < MAX_VERTS) begin
			if (fan_count == 0) begin
				fan_origin_x = x;
				fan_origin_y = y;
			end else if (fan_count >= 2) begin
				px = longint'(fan_prev_x) - longint'(fan_origin_x);
				py = longint'(fan_prev_y) - longint'(fan_origin_y);
				qx = longint'(x) - longint'(fan_origin_x);
				qy = longint'(y) - longint'(fan_origin_y);
				a2 = qx * py - qy * px;
				sx = longint'(fan_origin_x) + longint'(fan_prev_x) + longint'(x);
				sy = longint'(fan_origin_y) + longint'(fan_prev_y) + longint'(y);
				fan_area  = fan_area + a2[AREA_W-1:0];
				fan_mom_x = fan_mom_x + a2 * sx;
				fan_mom_y = fan_mom_y + a2 * sy;
			end
			fan_prev_x = x;
			fan_prev_y = y;
			fan_count++;
		end
		if (!is_last)
			return 1'b0;
		if (fan_count < 3 || fan_area == 0) begin
			res.degen = 1'b1;
		end else begin
			den_neg = fan_area[AREA_W-1];
			a_mag   = den_neg ? -fan_area : fan_area;
			den_mag = 3 * {{(MOM_W-AREA_W){1'b0}}, a_mag};
			sat     = 1'b0;
			res.cx  = round_centroid(fan_mom_x, den_neg, den_mag, sat);
			res.cy  = round_centroid(fan_mom_y, den_neg, den_mag, sat);
			res.sat = sat;
		end
		fan_count = 0;
		fan_area  = '0;
		fan_mom_x = '0;
		fan_mom_y = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t ns: centroid %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_centroid(input centroid_t got);
		centroid_t want;
		if (expected_centroids.size() == 0) begin
			report_mismatch("result with none pending, x", int'(got.cx), 0);
		end else begin
			want = expected_centroids.pop_front();
			if (got.cx !== want.cx)
				report_mismatch("x", int'(got.cx), int'(want.cx));
			if (got.cy !== want.cy)
				report_mismatch("y", int'(got.cy), int'(want.cy));
			if (got.degen !== want.degen)
				report_mismatch("degenerate", int'(got.degen), int'(want.degen));
			if (got.sat !== want.sat)
				report_mismatch("saturated", int'(got.sat), int'(want.sat));
		end
	endtask

	task automatic push_vertex(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
			input bit is_last, input bit typed, input centroid_t want);
		centroid_t res;
		int        gap;
		vertex_x    <= x;
		vertex_y    <= y;
		last_vertex <= is_last;
		push        <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (fan_step(x, y, is_last, res))
			expected_centroids.insert(expected_centroids.size(), typed ? want : res);
		sent_items++;
		gap = next_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_polygon(input int n, input shape_t shape);
		bit [COORD_W-1:0] bx, by, x0, y0, x1, y1;
		bit [COORD_W-1:0] rx [4];
		bit [COORD_W-1:0] ry [4];
		bit               flip;
		if (shape == SHAPE_RECT) begin
			x0 = COORD_W'($urandom_range(0, 65535));
			x1 = COORD_W'($urandom_range(0, 65535));
			y0 = COORD_W'($urandom_range(0, 65535));
			y1 = COORD_W'($urandom_range(0, 65535));
			flip = 1'($urandom_range(0, 1));
			rx = '{x0, x1, x1, x0};
			if (flip)
				ry = '{y1, y1, y0, y0};
			else
				ry = '{y0, y0, y1, y1};
			for (int i = 0; i < 4; i++)
				push_vertex(rx[i], ry[i], i == 3, 1'b0, NO_RESULT);
		end else begin
			bx = COORD_W'($urandom_range(0, 65535 - 15));
			by = COORD_W'($urandom_range(0, 65535 - 15));
			for (int i = 0; i < n; i++) begin
				if (shape == SHAPE_CLUSTER)
					push_vertex(COORD_W'(bx + $urandom_range(0, 15)),
						COORD_W'(by + $urandom_range(0, 15)),
						i == n - 1, 1'b0, NO_RESULT);
				else
					push_vertex(COORD_W'($urandom_range(0, 65535)),
						COORD_W'($urandom_range(0, 65535)),
						i == n - 1, 1'b0, NO_RESULT);
			end
		end
	endtask

	initial begin
		int pick, n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			push_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].is_last,
				directed_rows[i].typed, directed_rows[i].want);
		while (sent_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(3, 10);
			if (pick < 35)
				send_polygon(n, SHAPE_SCATTER);
			else if (pick < 65)
				send_polygon(n, SHAPE_CLUSTER);
			else if (pick < 90)
				send_polygon(4, SHAPE_RECT);
			else
				send_polygon($urandom_range(1, 2), SHAPE_SCATTER);
		end
		push <= 1'b0;
		while (expected_centroids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int        gap;
		int        seen;
		centroid_t got;
		seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			// one long hold-off so the input side backs up and stalls
			gap = (seen == HOLD_AT) ? HOLD_CYCLES : next_gap(recv_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got = '{centroid_x, centroid_y, degenerate, saturated};
			seen++;
			check_centroid(got);
		end
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- polygon_centroid_fan_core.f -----
sv/pcf_pkg.sv
sv/pcf_front.sv
sv/pcf_fifo.sv
sv/pcf_div.sv
sv/pcf_back.sv
sv/polygon_centroid_fan_core.sv
tb/tb_polygon_centroid_fan_core.sv
